// ===== rtl/cfir_pkg.sv =====
// Package for the complex FIR filter unit: item kinds, sequencer states,
// and the packed beat types of the input and result channels.
// Depends on nothing.
`default_nettype none

package cfir_pkg;

    typedef enum logic [1:0] {
        KIND_CPX  = 2'd0,
        KIND_REAL = 2'd1,
        KIND_COEF = 2'd2,
        KIND_RSVD = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic [5:0]         coef_index;
        logic signed [15:0] coef_re;
        logic signed [15:0] coef_im;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_re;
        logic signed [15:0] out_im;
    } t_out_item;

    localparam int unsigned CPX_W = 32;

endpackage

`default_nettype wire

// ===== rtl/cfir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cfir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/complex_fir_filter_unit.sv =====
// Complex FIR filter unit: circular sample history, complex tap store and
// one shared complex multiply-accumulate stepped once per tap.
// Depends on cfir_pkg and cfir_ram.
//
//  channel | beat type           | valid       | ready       | moves
//  --------+---------------------+-------------+-------------+---------------------------
//  input   | cfir_pkg::t_in_item | i_in_valid  | o_in_ready  | sample or coefficient load
//  result  | cfir_pkg::t_out_item| o_out_valid | i_out_ready | filtered sample
//
// A sample beat writes the history, then steps through every tap, reading both
// stores into the shared complex MAC, drains its pipeline and finally rounds
// and loads the result register.
// A coefficient load or an unused kind gives no result.
// After reset both stores are cleared before the first beat is taken.
// A held result only stalls the next sample in its final step, ST_DONE.
`default_nettype none

module complex_fir_filter_unit #(
    parameter int TAPS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire cfir_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cfir_pkg::t_out_item      o_out_item
);

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W = 34 + AW;
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

    localparam logic signed [ACC_W-1:0] RND   = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q_MIN = -ACC_W'(32768);

    cfir_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_pos;
    logic [AW-1:0] r_tap_cnt;
    logic          r_is_real;
    logic          r_rd_vld;
    logic          r_prod_vld;

    logic signed [31:0] r_prod_rr, r_prod_ii, r_prod_ri, r_prod_ir;
    logic signed [ACC_W-1:0] r_acc_re, r_acc_im;

    logic                      in_acc;
    logic                      is_sample;
    logic                      coef_ok;
    logic                      hist_we, coef_we;
    logic [AW-1:0]             hist_waddr, coef_waddr;
    logic [cfir_pkg::CPX_W-1:0] hist_wdata, coef_wdata;
    logic [cfir_pkg::CPX_W-1:0] hist_rdata, coef_rdata;
    logic                      out_free;
    logic                      out_load;
    logic signed [ACC_W-1:0]   t_re, t_im, q_re, q_im;
    logic signed [15:0]        sat_re, sat_im;

    assign in_acc    = i_in_valid && o_in_ready;
    assign is_sample = (i_in_item.kind == cfir_pkg::KIND_CPX) ||
                       (i_in_item.kind == cfir_pkg::KIND_REAL);
    assign coef_ok   = (i_in_item.kind == cfir_pkg::KIND_COEF) &&
                       (32'(i_in_item.coef_index) < 32'(TAPS));
    assign out_free  = !o_out_valid || i_out_ready;

    cfir_ram #(.WIDTH(cfir_pkg::CPX_W), .DEPTH(TAPS)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (r_rd_pos),
        .o_rdata (hist_rdata)
    );

    cfir_ram #(.WIDTH(cfir_pkg::CPX_W), .DEPTH(TAPS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (r_tap_cnt),
        .o_rdata (coef_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cfir_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST) n_state = cfir_pkg::ST_IDLE;
            end
            cfir_pkg::ST_IDLE: begin
                if (in_acc && is_sample) n_state = cfir_pkg::ST_RUN;
            end
            cfir_pkg::ST_RUN: begin
                if (r_tap_cnt == LAST) n_state = cfir_pkg::ST_DRAIN;
            end
            cfir_pkg::ST_DRAIN: begin
                if (!r_rd_vld && !r_prod_vld) n_state = cfir_pkg::ST_DONE;
            end
            cfir_pkg::ST_DONE: begin
                if (out_free) n_state = cfir_pkg::ST_IDLE;
            end
            default: n_state = cfir_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer: store writes, input ready and result load
    always_comb begin
        o_in_ready = 1'b0;
        hist_we    = 1'b0;
        coef_we    = 1'b0;
        hist_waddr = r_wr_ptr;
        coef_waddr = AW'(i_in_item.coef_index);
        hist_wdata = {i_in_item.sample_re,
                      (i_in_item.kind == cfir_pkg::KIND_REAL) ? 16'sd0
                                                              : i_in_item.sample_im};
        coef_wdata = {i_in_item.coef_re, i_in_item.coef_im};
        out_load   = 1'b0;
        case (r_state)
            cfir_pkg::ST_CLEAR: begin
                hist_we    = 1'b1;
                coef_we    = 1'b1;
                hist_waddr = r_clr_addr;
                coef_waddr = r_clr_addr;
                hist_wdata = '0;
                coef_wdata = '0;
            end
            cfir_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                hist_we    = i_in_valid && is_sample;
                coef_we    = i_in_valid && coef_ok;
            end
            cfir_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Round half up to Q1.15, then saturate
    always_comb begin
        t_re = r_acc_re + RND;
        t_im = r_acc_im + RND;
        q_re = t_re >>> 15;
        q_im = t_im >>> 15;
        if (q_re > Q_MAX)      sat_re = 16'sh7fff;
        else if (q_re < Q_MIN) sat_re = -16'sh8000;
        else                   sat_re = q_re[15:0];
        if (q_im > Q_MAX)      sat_im = 16'sh7fff;
        else if (q_im < Q_MIN) sat_im = -16'sh8000;
        else                   sat_im = q_im[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfir_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_wr_ptr    <= '0;
            r_rd_pos    <= '0;
            r_tap_cnt   <= '0;
            r_is_real   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_prod_vld  <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= (r_state == cfir_pkg::ST_RUN);
            r_prod_vld <= r_rd_vld;
            if (r_state == cfir_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (in_acc && is_sample) begin
                r_rd_pos  <= r_wr_ptr;
                r_tap_cnt <= '0;
                r_is_real <= (i_in_item.kind == cfir_pkg::KIND_REAL);
                r_wr_ptr  <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (r_state == cfir_pkg::ST_RUN) begin
                // walk the history backward, the taps forward
                r_rd_pos  <= (r_rd_pos == '0) ? LAST : r_rd_pos - AW'(1);
                r_tap_cnt <= r_tap_cnt + AW'(1);
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Shared complex MAC datapath
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod_rr <= signed'(hist_rdata[31:16]) * signed'(coef_rdata[31:16]);
            r_prod_ii <= signed'(hist_rdata[15:0])  * signed'(coef_rdata[15:0]);
            r_prod_ri <= signed'(hist_rdata[31:16]) * signed'(coef_rdata[15:0]);
            r_prod_ir <= signed'(hist_rdata[15:0])  * signed'(coef_rdata[31:16]);
        end
        if (in_acc && is_sample) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_prod_vld) begin
            // drop the imaginary cross term for a real sample; older
            // history entries may still hold imaginary parts
            r_acc_re <= r_acc_re + ACC_W'(r_prod_rr)
                        - (r_is_real ? ACC_W'(0) : ACC_W'(r_prod_ii));
            r_acc_im <= r_acc_im + ACC_W'(r_prod_ri) + ACC_W'(r_prod_ir);
        end
        if (out_load) begin
            o_out_item.out_re <= sat_re;
            o_out_item.out_im <= r_is_real ? 16'sd0 : sat_im;
        end
    end

    // A result beat appears only out of the final sequencer step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == cfir_pkg::ST_DONE)
        else $error("result beat raised outside final step");

    // Products reach the accumulator only while a sample is being filtered
    a_mac_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_vld |-> (r_state == cfir_pkg::ST_RUN || r_state == cfir_pkg::ST_DRAIN))
        else $error("MAC active outside of filtering");

    // A real sample yields a zero imaginary result
    a_real_im_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_is_real) |=> o_out_item.out_im == 16'sd0)
        else $error("real sample gave nonzero imaginary output");

    // The write pointer moves exactly once per accepted sample
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_sample) |=>
            r_wr_ptr == (($past(r_wr_ptr) == LAST) ? '0 : $past(r_wr_ptr) + AW'(1)))
        else $error("write pointer did not advance by one");

    // No input beat is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cfir_pkg::ST_CLEAR) |-> !o_in_ready)
        else $error("input taken while clearing stores");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for complex_fir_filter_unit: predicts each filtered
// beat from its own copy of the sample history and tap store, and checks results.
// Depends on cfir_pkg and the unit under test.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS = 64;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    cfir_pkg::t_in_item  i_in_item = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    cfir_pkg::t_out_item o_out_item;

    complex_fir_filter_unit #(.TAPS(TAPS)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Predictor state
    logic signed [15:0] hist_re [TAPS];
    logic signed [15:0] hist_im [TAPS];
    logic signed [15:0] tap_re [TAPS];
    logic signed [15:0] tap_im [TAPS];
    logic [5:0]         wr_ptr = '0;

    cfir_pkg::t_out_item pending_outputs [$];
    int                  mismatches = 0;
    int unsigned         cycle_count = 0;
    bit                  no_gaps = 1'b0;
    int                  rx_hold_cycles = 0;

    initial begin
        for (int i = 0; i < TAPS; i++) begin
            hist_re[i] = '0;
            hist_im[i] = '0;
            tap_re[i]  = '0;
            tap_im[i]  = '0;
        end
    end

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL complex_fir_filter_unit");
            $finish;
        end
    end

    function automatic logic signed [15:0] q15_round_sat(input longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> 15;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return 16'(q);
    endfunction

    // Update the predictor with one beat; has_out is set when a result follows.
    function automatic void predict_fir(input cfir_pkg::t_in_item it, output bit has_out,
                                        output cfir_pkg::t_out_item res);
        longint     acc_re;
        longint     acc_im;
        logic [5:0] pos;
        bit         is_real;
        acc_re  = 0;
        acc_im  = 0;
        has_out = 1'b0;
        res     = '0;
        if (it.kind == cfir_pkg::KIND_COEF) begin
            tap_re[it.coef_index] = it.coef_re;
            tap_im[it.coef_index] = it.coef_im;
            return;
        end
        if (it.kind == cfir_pkg::KIND_RSVD)
            return;
        is_real = (it.kind == cfir_pkg::KIND_REAL);
        hist_re[wr_ptr] = it.sample_re;
        hist_im[wr_ptr] = is_real ? 16'sd0 : it.sample_im;
        pos = wr_ptr;
        for (int i = 0; i < TAPS; i++) begin
            if (is_real) begin
                acc_re += longint'(hist_re[pos]) * longint'(tap_re[i]);
            end else begin
                acc_re += longint'(hist_re[pos]) * longint'(tap_re[i])
                        - longint'(hist_im[pos]) * longint'(tap_im[i]);
                acc_im += longint'(hist_re[pos]) * longint'(tap_im[i])
                        + longint'(hist_im[pos]) * longint'(tap_re[i]);
            end
            pos = pos - 6'd1;
        end
        wr_ptr = wr_ptr + 6'd1;
        res.out_re = q15_round_sat(acc_re);
        res.out_im = is_real ? 16'sd0 : q15_round_sat(acc_im);
        has_out = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Full-scale value, sometimes an extreme, optionally scaled down at random.
    function automatic logic signed [15:0] rand_q15(input bit scaled);
        logic signed [15:0] v;
        int r;
        v = 16'($urandom);
        r = $urandom_range(0, 15);
        if (r == 0)
            v = 16'sh8000;
        else if (r == 1)
            v = 16'sh7fff;
        if (scaled)
            v = v >>> $urandom_range(0, 9);
        return v;
    endfunction

    function automatic cfir_pkg::t_in_item rand_beat(input cfir_pkg::t_kind k);
        cfir_pkg::t_in_item it;
        it            = cfir_pkg::t_in_item'(72'({$urandom, $urandom, $urandom}));
        it.kind       = k;
        it.sample_re  = rand_q15(1'b0);
        it.sample_im  = rand_q15(1'b0);
        it.coef_re    = rand_q15(1'b1);
        it.coef_im    = rand_q15(1'b1);
        return it;
    endfunction

    task automatic send_beat(input cfir_pkg::t_in_item it);
        int                  gap;
        bit                  has_out;
        cfir_pkg::t_out_item res;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_fir(it, has_out, res);
        if (has_out)
            pending_outputs.push_back(res);
    endtask

    task automatic send_kind(input cfir_pkg::t_kind k, input logic signed [15:0] a,
                             input logic signed [15:0] b, input logic [5:0] idx);
        cfir_pkg::t_in_item it;
        it = rand_beat(k);
        if (k == cfir_pkg::KIND_COEF) begin
            it.coef_index = idx;
            it.coef_re    = a;
            it.coef_im    = b;
        end else begin
            it.sample_re = a;
            it.sample_im = b;
        end
        send_beat(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: long hold when asked, otherwise random stalls
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_gaps)
                    stall_left = pick_gap();
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        cfir_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                mismatches++;
                $display("%0t unexpected beat: expected none, actual re %0d im %0d",
                         $time, o_out_item.out_re, o_out_item.out_im);
            end else begin
                want = pending_outputs.pop_front();
                if (o_out_item.out_re !== want.out_re) begin
                    mismatches++;
                    $display("%0t out_re mismatch: expected %0d, actual %0d",
                             $time, want.out_re, o_out_item.out_re);
                end
                if (o_out_item.out_im !== want.out_im) begin
                    mismatches++;
                    $display("%0t out_im mismatch: expected %0d, actual %0d",
                             $time, want.out_im, o_out_item.out_im);
                end
            end
        end
    end

    // Extremes, every kind, the ignored kind and saturation of the sum
    task automatic test_directed();
        send_kind(cfir_pkg::KIND_RSVD, 16'sh7fff, 16'sh8000, 6'd5);
        send_kind(cfir_pkg::KIND_CPX,  16'sh7fff, 16'sh8000, 6'd0);
        send_kind(cfir_pkg::KIND_REAL, 16'sh8000, 16'sh7fff, 6'd0);
        send_kind(cfir_pkg::KIND_COEF, 16'sh8000, 16'sh8000, 6'd0);
        send_kind(cfir_pkg::KIND_COEF, 16'sh7fff, 16'sh7fff, 6'd63);
        send_kind(cfir_pkg::KIND_COEF, 16'sh8000, 16'sh7fff, 6'd1);
        send_kind(cfir_pkg::KIND_CPX,  16'sh8000, 16'sh8000, 6'd0);
        send_kind(cfir_pkg::KIND_CPX,  16'sh8000, 16'sh7fff, 6'd0);
        send_kind(cfir_pkg::KIND_REAL, 16'sh7fff, -16'sd1,   6'd0);
        send_kind(cfir_pkg::KIND_REAL, 16'sh8000, 16'sh0000, 6'd0);
        send_kind(cfir_pkg::KIND_CPX,  16'sh7fff, 16'sh7fff, 6'd0);
        send_kind(cfir_pkg::KIND_COEF, 16'sh0001, 16'sh0000, 6'd2);
        send_kind(cfir_pkg::KIND_CPX,  16'sh0000, 16'sh0000, 6'd0);
        send_kind(cfir_pkg::KIND_RSVD, 16'sh1234, 16'sh4321, 6'd63);
        send_kind(cfir_pkg::KIND_REAL, 16'sh0001, 16'sh7fff, 6'd0);
    endtask

    task automatic test_random_mix(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_beat(rand_beat(cfir_pkg::KIND_CPX));
            else if (r < 70)
                send_beat(rand_beat(cfir_pkg::KIND_REAL));
            else if (r < 95)
                send_beat(rand_beat(cfir_pkg::KIND_COEF));
            else
                send_beat(rand_beat(cfir_pkg::KIND_RSVD));
        end
    endtask

    // Hold the result side off so the unit fills and stalls its input
    task automatic test_backpressure();
        no_gaps = 1'b1;
        rx_hold_cycles = 400;
        for (int n = 0; n < 30; n++)
            send_beat(rand_beat($urandom_range(0, 1) ? cfir_pkg::KIND_CPX
                                                     : cfir_pkg::KIND_REAL));
        no_gaps = 1'b0;
    endtask

    task automatic test_pause_drain();
        for (int k = 0; k < 3; k++) begin
            test_random_mix(20);
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        test_random_mix(150);
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(700);
        test_backpressure();
        test_pause_drain();
        test_back_to_back();
        test_random_mix(600);

        wait_drained();
        repeat (TAPS + 8) @(posedge i_clk);
        if (mismatches == 0 && pending_outputs.size() == 0)
            $display("PASS complex_fir_filter_unit");
        else
            $display("FAIL complex_fir_filter_unit");
        $finish;
    end

endmodule
